// ===== sv/xpu_pkg.sv =====
// Shared constants, queue entry type and byte select helpers for the
// XOR payload unscrambler. No dependencies; every other file imports it.
package xpu_pkg;

  // Sizing of the stream state
  localparam int MAX_HEADERS    = 16;
  localparam int HEADER_SKIP    = 18;
  localparam int KEY_BYTES      = 12;
  localparam int MAX_NAME_BYTES = 24;

  // Bytes actually held by the name and key registers
  localparam int NAME_STORED = 24;
  localparam int KEY_STORED  = 12;

  localparam int RAW_W      = 32;
  localparam int SLOT_W     = $clog2(MAX_HEADERS + 1);
  localparam int SLOT_IDX_W = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
  localparam int SKIP_W     = $clog2(HEADER_SKIP + 1);
  localparam int KEY_IDX_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int NAME_LEN_W = 5;
  localparam int NAME_IDX_W = 5;
  localparam int CHARS_W    = 5;
  localparam logic [CHARS_W-1:0] CHARS_MAX = '1;
  localparam logic [RAW_W-1:0]   RAW_MAX   = '1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_MID  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_LOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES_HIGH  = 3'd5;

  // Input commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_NAME    = 1'b1;

  // Decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One kept byte: optional name character, then the payload byte
  typedef struct packed {
    logic       has_name;
    logic [7:0] name_char;
    logic [7:0] pay_byte;
  } entry_t;

  // Scrambled name byte i, zero beyond the stored bytes
  function automatic logic [7:0] name_byte(input logic [NAME_STORED*8-1:0] names,
                                           input logic [NAME_IDX_W-1:0]    i);
    logic [7:0] b;
    b = 8'h00;
    if (32'(i) < NAME_STORED) b = names[{i, 3'b000} +: 8];
    return b;
  endfunction

  // Key byte i, zero beyond the stored bytes
  function automatic logic [7:0] key_byte(input logic [KEY_STORED*8-1:0] keys,
                                          input logic [KEY_IDX_W-1:0]    i);
    logic [7:0] b;
    b = 8'h00;
    if (32'(i) < KEY_STORED) b = keys[{i, 3'b000} +: 8];
    return b;
  endfunction

endpackage

// ===== sv/xpu_front.sv =====
// Front end: configuration registers, offset table and stream counters.
// Classifies each accepted item and pushes kept bytes to the queue. Uses xpu_pkg.
module xpu_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [xpu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [xpu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         command,
  input  logic [31:0]                        offset_value,
  input  logic [7:0]                         data_byte,
  input  logic                               q_full,
  output logic                               push,
  output xpu_pkg::entry_t                    push_entry
);
  import xpu_pkg::*;

  // Configuration registers
  logic [NAME_LEN_W-1:0]    name_length;
  logic [NAME_STORED*8-1:0] name_bytes;
  logic [KEY_STORED*8-1:0]  key_bytes;

  // Stream state
  logic [RAW_W-1:0]      offset_table [MAX_HEADERS];
  logic [SLOT_W-1:0]     offsets_loaded;
  logic [SLOT_W-1:0]     next_offset_slot;
  logic [RAW_W-1:0]      raw_position;
  logic [SKIP_W-1:0]     skip_left;
  logic [NAME_IDX_W-1:0] name_key_index;
  logic [CHARS_W-1:0]    name_chars_out;
  logic [KEY_IDX_W-1:0]  key_pos;

  logic                  accept;
  logic                  kept;
  logic [NAME_LEN_W-1:0] eff_len;
  logic                  name_hit;
  logic [KEY_IDX_W-1:0]  key_sel;
  logic [NAME_IDX_W-1:0] pay_idx;
  logic [RAW_W-1:0]      raw_next;
  logic                  hdr_hit;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign kept       = accept && (command == CMD_DATA) && (skip_left == '0);

  // Clamp the name length to the usable range
  always_comb begin
    eff_len = name_length;
    if (name_length == '0) begin
      eff_len = NAME_LEN_W'(1);
    end else if (32'(name_length) > MAX_NAME_BYTES) begin
      eff_len = NAME_LEN_W'(MAX_NAME_BYTES);
    end
  end

  // Classify the byte and form both results
  assign name_hit = raw_position < RAW_W'(eff_len);
  assign key_sel  = name_chars_out[0] ? key_pos : (KEY_IDX_W'(KEY_BYTES - 1) - key_pos);
  assign pay_idx  = (name_key_index >= NAME_IDX_W'(eff_len)) ? '0 : name_key_index;
  assign raw_next = (raw_position == RAW_MAX) ? raw_position : raw_position + RAW_W'(1);
  assign hdr_hit  = (next_offset_slot < offsets_loaded) &&
                    (raw_next == offset_table[next_offset_slot[SLOT_IDX_W-1:0]]);

  assign push                 = kept;
  assign push_entry.has_name  = name_hit;
  assign push_entry.name_char = name_byte(name_bytes, raw_position[NAME_IDX_W-1:0]) ^
                                key_byte(key_bytes, key_sel);
  assign push_entry.pay_byte  = data_byte ^ name_byte(name_bytes, pay_idx);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= NAME_LEN_W'(1);
      name_bytes  <= '0;
      key_bytes   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NAME_LENGTH:     name_length       <= cfg_data[NAME_LEN_W-1:0];
        REG_NAME_BYTES_LOW:  name_bytes[63:0]   <= cfg_data;
        REG_NAME_BYTES_MID:  name_bytes[127:64] <= cfg_data;
        REG_NAME_BYTES_HIGH: name_bytes[191:128] <= cfg_data;
        REG_KEY_BYTES_LOW:   key_bytes[63:0]    <= cfg_data;
        REG_KEY_BYTES_HIGH:  key_bytes[95:64]   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Offset table: written in load order, read only below the fill count
  always_ff @(posedge clk) begin
    if (accept && (command == CMD_LOAD) && (32'(offsets_loaded) < MAX_HEADERS)) begin
      offset_table[offsets_loaded[SLOT_IDX_W-1:0]] <= offset_value;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets_loaded   <= '0;
      next_offset_slot <= '0;
      raw_position     <= '0;
      skip_left        <= '0;
      name_key_index   <= '0;
      name_chars_out   <= '0;
      key_pos          <= '0;
    end else if (accept) begin
      unique case (command)
        CMD_CLEAR: begin
          offsets_loaded   <= '0;
          next_offset_slot <= '0;
          raw_position     <= '0;
          skip_left        <= '0;
          name_key_index   <= '0;
          name_chars_out   <= '0;
          key_pos          <= '0;
        end
        CMD_LOAD: begin
          if (32'(offsets_loaded) < MAX_HEADERS) begin
            offsets_loaded <= offsets_loaded + SLOT_W'(1);
          end
        end
        CMD_DATA: begin
          raw_position <= raw_next;
          if (skip_left != '0) begin
            // drop a header byte
            skip_left <= skip_left - SKIP_W'(1);
          end else begin
            name_key_index <= pay_idx + NAME_IDX_W'(1);
            if (name_hit && (name_chars_out != CHARS_MAX)) begin
              name_chars_out <= name_chars_out + CHARS_W'(1);
              key_pos <= (key_pos == KEY_IDX_W'(KEY_BYTES - 1)) ? '0 :
                         key_pos + KEY_IDX_W'(1);
            end
            if (hdr_hit) begin
              skip_left        <= SKIP_W'(HEADER_SKIP);
              next_offset_slot <= next_offset_slot + SLOT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/xpu_queue.sv =====
// Short show-ahead queue between the front and back ends.
// Holds kept-byte entries; depends on xpu_pkg for the entry type.
module xpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xpu_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output xpu_pkg::entry_t head
);
  import xpu_pkg::*;

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (32'(count) == Q_DEPTH);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/xpu_back.sv =====
// Back end: expands each queue entry into one or two result transfers
// through a single output register. Depends on xpu_pkg.
module xpu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  xpu_pkg::entry_t head,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic            kind,
  output logic [7:0]      value,
  output logic            last_of_run
);
  import xpu_pkg::*;

  logic load;
  logic name_done;
  logic send_name;

  // Output register free or emptying this cycle
  assign load      = !result_valid || !result_stall;
  assign send_name = head.has_name && !name_done;
  assign pop       = load && head_valid && !send_name;

  // Control: output valid and name phase
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      name_done    <= 1'b0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        name_done <= send_name;
      end
    end
  end

  // Payload: name character first, then the payload byte
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (send_name) begin
        kind        <= KIND_NAME;
        value       <= head.name_char;
        last_of_run <= 1'b0;
      end else begin
        kind        <= KIND_PAYLOAD;
        value       <= head.pay_byte;
        last_of_run <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/xor_payload_unscrambler.sv =====
// Top level of the XOR payload unscrambler: front end, queue and back end.
// Depends on xpu_pkg, xpu_front, xpu_queue and xpu_back.
//
// Accepts one input item per clock cycle when the queue has room: clear,
// load header offset, or a raw payload byte. Each kept payload byte gives
// one result, or two (name character, then payload byte) when its raw
// position lies below the name length; the single output register sends
// one result per cycle unless stalled, so such a byte occupies the output
// for both results and the four-entry queue absorbs the difference.
// Dropped header bytes, loads and clears give no result. Configuration
// writes are always taken (cfg_ready held high); the user must issue them
// only while the block is idle, which the block itself does not enforce.
module xor_payload_unscrambler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xpu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      command,
  input  logic [31:0]                     offset_value,
  input  logic [7:0]                      data_byte,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            kind,
  output logic [7:0]                      value,
  output logic                            last_of_run
);
  import xpu_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  assign cfg_ready = 1'b1;

  xpu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .offset_value (offset_value),
    .data_byte    (data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  xpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  xpu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .value        (value),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== sv/xpu_checker.sv =====
// Port-level checks for the XOR payload unscrambler, bound to the top level.
// Depends on xpu_pkg for the result kinds.
module xpu_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic       kind,
  input logic [7:0] value,
  input logic       last_of_run
);
  import xpu_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(kind) && $stable(value) && $stable(last_of_run))
    else $error("stalled result changed");

  // A name character never closes a run
  a_name_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_NAME) |-> !last_of_run)
    else $error("name character marked last");

  // A payload byte always closes a run
  a_pay_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_PAYLOAD) |-> last_of_run)
    else $error("payload byte not marked last");

  // After a name character transfer, the next result is its payload byte
  a_name_then_pay: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && (kind == KIND_NAME) |=>
      !result_valid || (kind == KIND_PAYLOAD))
    else $error("name character not followed by payload byte");

endmodule

bind xor_payload_unscrambler xpu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .kind         (kind),
  .value        (value),
  .last_of_run  (last_of_run)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the XOR payload unscrambler: streams clears,
// header offset loads and payload bytes, predicts every name character and
// payload byte in order. Depends on xpu_pkg and xor_payload_unscrambler.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xpu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_ITEMS    = 600;
  localparam int PHASE_ITEMS     = 100;
  localparam int MAX_WAIT        = 13;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] offset;
    logic [7:0]  data;
  } stream_item_t;

  typedef struct {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } out_byte_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [1:0]             command = CMD_CLEAR;
  logic [31:0]            offset_value = '0;
  logic [7:0]             data_byte = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   kind;
  logic [7:0]             value;
  logic                   last_of_run;

  // Register copies and stream state of the predictor
  logic [4:0]               name_len_reg;
  logic [NAME_STORED*8-1:0] name_reg;
  logic [KEY_STORED*8-1:0]  key_reg;
  logic [31:0]              hdr_table [MAX_HEADERS];
  logic [4:0]               hdr_loaded, hdr_next, skip_left, key_idx, chars_out;
  logic [31:0]              raw_pos;

  stream_item_t pending_items [$];
  out_byte_t    expected_out [$];
  stream_item_t drive_item, sampled_item;
  out_byte_t    want;

  bit took_item = 1'b0;
  bit took_result = 1'b0;
  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int pressure_reqs = 0;
  int pressure_seen = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int error_count = 0;

  xor_payload_unscrambler DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .offset_value (offset_value),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .value        (value),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [7:0] name_at(input int unsigned i);
    return (i < NAME_STORED) ? name_reg[i*8 +: 8] : 8'h00;
  endfunction

  function automatic void clear_stream();
    foreach (hdr_table[i]) hdr_table[i] = '0;
    hdr_loaded = '0;
    hdr_next   = '0;
    raw_pos    = '0;
    skip_left  = '0;
    key_idx    = '0;
    chars_out  = '0;
  endfunction

  function automatic void unscramble_item(input stream_item_t it);
    int unsigned len, idx, kpos;
    case (it.cmd)
      CMD_CLEAR: clear_stream();
      CMD_LOAD: begin
        // ignore loads once the table is full
        if (hdr_loaded < MAX_HEADERS) begin
          hdr_table[hdr_loaded] = it.offset;
          hdr_loaded++;
        end
      end
      CMD_DATA: begin
        if (skip_left > 0) begin
          // drop a header byte, but count its position
          skip_left--;
          if (raw_pos != '1) raw_pos++;
        end else begin
          len = name_len_reg;
          if (len == 0) len = 1;
          if (len > MAX_NAME_BYTES) len = MAX_NAME_BYTES;
          // name character first while inside the name area
          if (raw_pos < len) begin
            kpos = chars_out % KEY_BYTES;
            if (!chars_out[0]) kpos = KEY_BYTES - 1 - kpos;
            expected_out.push_back('{KIND_NAME, name_at(raw_pos) ^ key_reg[kpos*8 +: 8],
                                     1'b0});
            if (chars_out < 31) chars_out++;
          end
          idx = (key_idx >= len) ? 0 : key_idx;
          expected_out.push_back('{KIND_PAYLOAD, it.data ^ name_at(idx), 1'b1});
          key_idx = 5'(idx + 1);
          if (raw_pos != '1) raw_pos++;
          // arm the header skip when the next offset is reached
          if (hdr_next < hdr_loaded && hdr_next < MAX_HEADERS &&
              raw_pos == hdr_table[hdr_next]) begin
            skip_left = 5'(HEADER_SKIP);
            hdr_next++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("MISMATCH %s: expected %0h, got %0h", what, want_v, got_v);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer pending items, hold each until its transfer
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!item_valid || took_item) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        command      <= drive_item.cmd;
        offset_value <= drive_item.offset;
        data_byte    <= drive_item.data;
        item_valid   <= 1'b1;
        send_gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: may stall after each transfer, or hold off on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (pressure_seen != pressure_reqs) begin
        pressure_seen = pressure_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (took_result) recv_wait = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted item
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      took_item   <= 1'b0;
      took_result <= 1'b0;
    end else begin
      took_result <= result_valid && !result_stall;
      took_item   <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        if (expected_out.size() == 0) begin
          report_mismatch("result with nothing expected, value", 0, value);
        end else begin
          want = expected_out.pop_front();
          if (kind !== want.kind) report_mismatch("kind", want.kind, kind);
          if (value !== want.value) report_mismatch("value", want.value, value);
          if (last_of_run !== want.last) report_mismatch("last_of_run", want.last, last_of_run);
        end
      end
      if (item_valid && !item_stall) begin
        sampled_item.cmd    = command;
        sampled_item.offset = offset_value;
        sampled_item.data   = data_byte;
        unscramble_item(sampled_item);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input logic [1:0] cmd, input logic [31:0] off,
                           input logic [7:0] dat);
    stream_item_t it;
    it.cmd    = cmd;
    it.offset = off;
    it.data   = dat;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NAME_LENGTH:     name_len_reg = val[4:0];
      REG_NAME_BYTES_LOW:  name_reg[63:0] = val;
      REG_NAME_BYTES_MID:  name_reg[127:64] = val;
      REG_NAME_BYTES_HIGH: name_reg[191:128] = val;
      REG_KEY_BYTES_LOW:   key_reg[63:0] = val;
      REG_KEY_BYTES_HIGH:  key_reg[95:64] = val[31:0];
      default: ;
    endcase
  endtask

  // Write every register, then return on a rising edge
  task automatic program_setting(input logic [4:0] len, input logic [191:0] names,
                                 input logic [95:0] keys);
    write_reg(REG_NAME_LENGTH, 64'(len));
    write_reg(REG_NAME_BYTES_LOW, names[63:0]);
    write_reg(REG_NAME_BYTES_MID, names[127:64]);
    write_reg(REG_NAME_BYTES_HIGH, names[191:128]);
    write_reg(REG_KEY_BYTES_LOW, keys[63:0]);
    write_reg(REG_KEY_BYTES_HIGH, {32'h0, keys[95:64]});
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every item and result to pass, then let the pipeline settle
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || item_valid || expected_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One frame: usually a clear, increasing header offsets, then payload
  // bytes with the odd stray load or unused command mixed in
  task automatic queue_frame(output int count);
    int loads, nbytes, i;
    logic [31:0] pos;
    count = 0;
    if ($urandom_range(0, 7) != 0) begin
      push_item(CMD_CLEAR, $urandom, 8'($urandom));
      count++;
    end
    loads = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 4);
    pos = $urandom_range(0, 20);
    for (i = 0; i < loads; i++) begin
      if ($urandom_range(0, 11) == 0) push_item(CMD_LOAD, $urandom, 8'($urandom));
      else push_item(CMD_LOAD, pos, 8'($urandom));
      pos += $urandom_range(1, 25);
      count++;
    end
    nbytes = $urandom_range(4, 60);
    for (i = 0; i < nbytes; i++) begin
      case ($urandom_range(0, 24))
        0: push_item(CMD_UNUSED, $urandom, 8'($urandom));
        1: begin
          push_item(CMD_LOAD, pos, 8'($urandom));
          pos += $urandom_range(1, 25);
          count++;
        end
        default: begin
          push_item(CMD_DATA, $urandom, 8'($urandom));
          count++;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int phase, random_total, phase_total, n, i;
    logic [4:0]   len;
    logic [95:0]  keys;
    name_len_reg = 5'd1;
    name_reg = '0;
    key_reg = '0;
    clear_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Longest name; zero offset pins the table pointer, then a header at 1
    // with a second offset buried inside its skipped run
    program_setting(5'd24, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom},
                    {$urandom, $urandom, $urandom});
    push_item(CMD_CLEAR, $urandom, 8'($urandom));
    push_item(CMD_LOAD, 32'h0, 8'($urandom));
    push_item(CMD_DATA, $urandom, 8'h00);
    push_item(CMD_DATA, $urandom, 8'hFF);
    push_item(CMD_UNUSED, $urandom, 8'($urandom));
    push_item(CMD_CLEAR, $urandom, 8'($urandom));
    push_item(CMD_LOAD, 32'd1, 8'($urandom));
    push_item(CMD_LOAD, 32'd8, 8'($urandom));
    for (i = 0; i < 22; i++) push_item(CMD_DATA, $urandom, 8'($urandom));
    wait_idle();

    // Zero length counts as one; the name index restarts mid-stream
    program_setting(5'd0, '1, '0);
    push_item(CMD_DATA, $urandom, 8'h5A);
    push_item(CMD_DATA, $urandom, 8'hA5);
    push_item(CMD_CLEAR, $urandom, 8'($urandom));
    push_item(CMD_DATA, $urandom, 8'($urandom));
    push_item(CMD_DATA, $urandom, 8'($urandom));
    wait_idle();

    // Random phases, one of them under a long receiver hold-off
    phase = 0;
    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      case (phase)
        0: len = 5'd31;
        1: len = 5'd1;
        2: len = 5'd24;
        default: len = 5'($urandom_range(0, 31));
      endcase
      keys = (phase == 1) ? '1 : {$urandom, $urandom, $urandom};
      program_setting(len, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom},
                      keys);
      sender_idle   = (phase == 0 || phase == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      receiver_idle = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      phase_total = 0;
      while (phase_total < PHASE_ITEMS) begin
        queue_frame(n);
        phase_total += n;
      end
      if (phase == 2) pressure_reqs++;
      wait_idle();
      random_total += phase_total;
      phase++;
    end

    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== xor_payload_unscrambler.f =====
sv/xpu_pkg.sv
sv/xpu_front.sv
sv/xpu_queue.sv
sv/xpu_back.sv
sv/xor_payload_unscrambler.sv
sv/xpu_checker.sv
tb/tb_top.sv
